// File: design/pma_pkg.sv
// ----------------------------------------------------------------------------
// pma_pkg: shared definitions of the primed moving average
// Sample width, default window, controller states and divider status.
// ----------------------------------------------------------------------------
package pma_pkg;

    localparam int SAMPLE_W       = 12;
    localparam int SAMPLE_MAX     = 4095;
    localparam int WINDOW_DEFAULT = 8;

    // controller states, one-hot
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_HOLD = 3'b100
    } t_state;

    // divider status toward the controller
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_status;

endpackage

// File: design/pma_sample_if.sv
// ----------------------------------------------------------------------------
// pma_sample_if: sample input channel
// Valid/ready channel carrying one raw converter sample per beat.
// ----------------------------------------------------------------------------
interface pma_sample_if;
    logic                           valid;
    logic                           ready;
    logic [pma_pkg::SAMPLE_W-1:0]   adc_sample;

    modport source (output valid, output adc_sample, input ready);
    modport sink   (input valid, input adc_sample, output ready);
endinterface

// File: design/pma_result_if.sv
// ----------------------------------------------------------------------------
// pma_result_if: filtered result channel
// Valid/ready channel carrying one filtered value per beat.
// ----------------------------------------------------------------------------
interface pma_result_if;
    logic                           valid;
    logic                           ready;
    logic [pma_pkg::SAMPLE_W-1:0]   filtered_value;

    modport source (output valid, output filtered_value, input ready);
    modport sink   (input valid, input filtered_value, output ready);
endinterface

// File: design/pma_cfg_if.sv
// ----------------------------------------------------------------------------
// pma_cfg_if: configuration write channel
// Valid/ready channel carrying the averaging enable bit.
// ----------------------------------------------------------------------------
interface pma_cfg_if;
    logic   valid;
    logic   ready;
    logic   average_enable;

    modport source (output valid, output average_enable, input ready);
    modport sink   (input valid, input average_enable, output ready);
endinterface

// File: design/primed_moving_average.sv
// ----------------------------------------------------------------------------
// primed_moving_average: rounded boxcar average of a 12-bit sample stream
// Keeps the last WINDOW samples in a chain of cells with a running sum.
// ----------------------------------------------------------------------------
// Usage:
//   i_sample carries one converter sample per beat, o_result one filtered
//   value per beat, i_cfg writes the averaging enable (always ready).
//   The user must write configuration only while no item is in flight;
//   the block itself does not enforce it. Bypass (enable low or WINDOW of
//   1) and the priming sample return the sample itself: the result is held
//   in the controller, then loaded into the output register, and the next
//   sample is taken once the controller is back in idle. An averaged
//   sample advances the cell chain and the running sum in the accept
//   cycle, the divider latches the rounded sum and multiplies it by the
//   window reciprocal in the next cycle; the controller holds the quotient
//   when the divider is done and no new sample is taken until it moves on.
//   The output register frees the controller: the next sample is taken
//   while a result waits. When the receiver stalls, a finished result waits
//   in the controller and no new sample is taken until it moves on.
//   Reset clears the primed flag, the running sum and the handshakes and
//   sets the enable; the history cells are filled by the priming sample.
// ----------------------------------------------------------------------------
module primed_moving_average #(
    parameter int WINDOW = pma_pkg::WINDOW_DEFAULT
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    pma_sample_if.sink   i_sample,
    pma_result_if.source o_result,
    pma_cfg_if.sink      i_cfg
);

    localparam int  SW     = pma_pkg::SAMPLE_W;
    localparam int  SUMW   = $clog2(WINDOW * pma_pkg::SAMPLE_MAX + 1);
    localparam int  DW     = $clog2(WINDOW * pma_pkg::SAMPLE_MAX + WINDOW / 2 + 1);
    localparam bit  PASS   = (WINDOW == 1);

    pma_pkg::t_state        r_state, n_state;
    logic                   r_enable;
    logic                   r_primed, n_primed;
    logic [SUMW-1:0]        r_sum, n_sum;
    logic [SW-1:0]          r_res, n_res;
    logic                   r_out_valid, n_out_valid;
    logic [SW-1:0]          r_out_value, n_out_value;

    logic                   w_accept;
    logic                   w_bypass;
    logic                   w_prime;
    logic                   w_shift;
    logic                   w_load_out;
    logic [SUMW-1:0]        w_avg_sum;
    logic [DW-1:0]          w_dividend;
    logic [SW-1:0]          w_tap [WINDOW];
    pma_pkg::t_div_status   w_div;
    logic [SW-1:0]          w_quo;

    // input handshake
    assign i_sample.ready = (r_state == pma_pkg::S_IDLE);
    assign w_accept       = i_sample.valid && i_sample.ready;
    assign w_bypass       = !r_enable || PASS;
    assign w_prime        = w_accept && !w_bypass && !r_primed;
    assign w_shift        = w_accept && !w_bypass && r_primed;

    // configuration always taken
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b1;
        end else if (i_cfg.valid) begin
            r_enable <= i_cfg.average_enable;
        end
    end

    // history chain: cell 0 takes the new sample, the last cell is the oldest
    for (genvar k = 0; k < WINDOW; k++) begin : g_cell
        logic [SW-1:0] w_prev;
        if (k == 0) begin : g_head
            assign w_prev = i_sample.adc_sample;
        end else begin : g_link
            assign w_prev = w_tap[k-1];
        end
        pma_cell u_cell (
            .i_clk   (i_clk),
            .i_prime (w_prime),
            .i_shift (w_shift),
            .i_fill  (i_sample.adc_sample),
            .i_prev  (w_prev),
            .o_value (w_tap[k])
        );
    end

    // drop the oldest sample, add the new one, round
    assign w_avg_sum  = r_sum - SUMW'(w_tap[WINDOW-1]) + SUMW'(i_sample.adc_sample);
    assign w_dividend = DW'(w_avg_sum) + DW'(WINDOW / 2);

    pma_div #(
        .WINDOW (WINDOW),
        .DW     (DW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_shift),
        .i_dividend (w_dividend),
        .o_status   (w_div),
        .o_quotient (w_quo)
    );

    // output register loads from the held result
    assign w_load_out = (r_state == pma_pkg::S_HOLD) && (!r_out_valid || o_result.ready);

    // controller
    always_comb begin
        n_state  = r_state;
        n_primed = r_primed;
        n_sum    = r_sum;
        n_res    = r_res;
        case (r_state)
            pma_pkg::S_IDLE: begin
                if (w_accept) begin
                    if (w_bypass) begin
                        n_primed = 1'b0;
                        n_res    = i_sample.adc_sample;
                        n_state  = pma_pkg::S_HOLD;
                    end else if (!r_primed) begin
                        n_primed = 1'b1;
                        n_sum    = SUMW'(i_sample.adc_sample) * SUMW'(WINDOW);
                        n_res    = i_sample.adc_sample;
                        n_state  = pma_pkg::S_HOLD;
                    end else begin
                        n_sum    = w_avg_sum;
                        n_state  = pma_pkg::S_DIV;
                    end
                end
            end
            pma_pkg::S_DIV: begin
                if (w_div.done) begin
                    n_res   = w_quo;
                    n_state = pma_pkg::S_HOLD;
                end
            end
            pma_pkg::S_HOLD: begin
                if (w_load_out) begin
                    n_state = pma_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = pma_pkg::S_IDLE;
            end
        endcase
    end

    // output register
    always_comb begin
        n_out_valid = r_out_valid;
        n_out_value = r_out_value;
        if (w_load_out) begin
            n_out_valid = 1'b1;
            n_out_value = r_res;
        end else if (o_result.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pma_pkg::S_IDLE;
            r_primed    <= 1'b0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_primed    <= n_primed;
            r_sum       <= n_sum;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res       <= n_res;
        r_out_value <= n_out_value;
    end

    assign o_result.valid          = r_out_valid;
    assign o_result.filtered_value = r_out_value;

    // no sample taken while the divider works
    a_busy_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div.busy |-> !i_sample.ready)
        else $error("sample accepted during division");

    // divider finishes only while the controller waits for it
    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div.done |-> (r_state == pma_pkg::S_DIV))
        else $error("divider done outside division state");

    // a bypassed sample leaves the block unprimed with a result held
    a_bypass_unprimes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_bypass) |=> (!r_primed && r_state == pma_pkg::S_HOLD))
        else $error("bypass did not clear primed flag");

endmodule

// File: design/pma_cell.sv
// ----------------------------------------------------------------------------
// pma_cell: one history cell
// Holds one past sample; loads the broadcast sample when priming, takes the
// neighbor's sample when the history advances.
// ----------------------------------------------------------------------------
module pma_cell (
    input  logic                            i_clk,
    input  logic                            i_prime,
    input  logic                            i_shift,
    input  logic [pma_pkg::SAMPLE_W-1:0]    i_fill,
    input  logic [pma_pkg::SAMPLE_W-1:0]    i_prev,
    output logic [pma_pkg::SAMPLE_W-1:0]    o_value
);

    logic [pma_pkg::SAMPLE_W-1:0] r_value;

    // prime from broadcast, else advance from neighbor
    always_ff @(posedge i_clk) begin
        if (i_prime) begin
            r_value <= i_fill;
        end else if (i_shift) begin
            r_value <= i_prev;
        end
    end

    assign o_value = r_value;

endmodule

// File: design/pma_div.sv
// ----------------------------------------------------------------------------
// pma_div: reciprocal divider by the window length
// Latches the dividend, then multiplies it by the rounded-up reciprocal of
// the window length and keeps the upper product bits. The quotient is exact
// for every dividend of DW bits and is known to fit in the sample width.
// ----------------------------------------------------------------------------
module pma_div #(
    parameter int WINDOW = pma_pkg::WINDOW_DEFAULT,
    parameter int DW     = $clog2(WINDOW * pma_pkg::SAMPLE_MAX + WINDOW / 2 + 1)
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [DW-1:0]                   i_dividend,
    output pma_pkg::t_div_status            o_status,
    output logic [pma_pkg::SAMPLE_W-1:0]    o_quotient
);

    localparam int QW    = pma_pkg::SAMPLE_W;
    localparam int LW    = $clog2(WINDOW);
    localparam int SHIFT = DW + LW;
    localparam int MW    = DW + 2;
    localparam int PW    = DW + MW;
    localparam logic [MW-1:0] RECIP =
        MW'(((64'd1 << SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));

    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [DW-1:0] r_dvd,  n_dvd;
    logic [QW-1:0] r_quo,  n_quo;
    logic [PW-1:0] w_prod;

    // scale by the reciprocal
    assign w_prod = PW'(r_dvd) * PW'(RECIP);

    // latch on start, take the quotient in the following cycle
    always_comb begin
        n_busy = 1'b0;
        n_done = 1'b0;
        n_dvd  = r_dvd;
        n_quo  = r_quo;
        if (i_start) begin
            n_busy = 1'b1;
            n_dvd  = i_dividend;
        end else if (r_busy) begin
            n_done = 1'b1;
            n_quo  = w_prod[SHIFT +: QW];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_dvd <= n_dvd;
        r_quo <= n_quo;
    end

    assign o_status.busy = r_busy;
    assign o_status.done = r_done;
    assign o_quotient    = r_quo;

endmodule
